[design/tprh_pkg.sv]
// Package for the touch panel report handler: item types, register codes, key remap.
package tprh_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned HOLD_W     = 7;
    localparam int unsigned NUM_KEYS   = 3;
    localparam int unsigned HOLDS_W    = HOLD_W * NUM_KEYS;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [BYTE_W-1:0]   SLIDER_IDLE   = 8'h80;
    localparam logic [BYTE_W-1:0]   SLIDER_A_BASE = 8'd127;
    localparam logic [BYTE_W-1:0]   LED_FULL      = 8'd255;
    localparam logic [BYTE_W-1:0]   LED_OFF       = 8'd0;
    localparam logic [BYTE_W-1:0]   BLUE_STEP     = 8'd5;
    localparam logic [BYTE_W-1:0]   BLUE_TOP      = 8'd255;
    localparam logic [BYTE_W-1:0]   COUNT_MAX     = 8'd255;
    localparam logic [NUM_KEYS-1:0] ALL_KEYS      = 3'b111;

    localparam logic [BYTE_W-1:0] LONG_PRESS_RESET = 8'd250;
    localparam logic [HOLD_W-1:0] HOLD_LIMIT_RESET = 7'd100;

    // Key codes whose bits 0 and 2 come swapped from the panel
    localparam logic [BYTE_W-1:0] KEY_CODE_1 = 8'h31;
    localparam logic [BYTE_W-1:0] KEY_CODE_4 = 8'h34;
    localparam logic [BYTE_W-1:0] KEY_CODE_3 = 8'h33;
    localparam logic [BYTE_W-1:0] KEY_CODE_6 = 8'h36;

    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_LIMIT = 1'd1;

    typedef struct packed {
        logic [BYTE_W-1:0] slider_a_raw;
        logic [BYTE_W-1:0] slider_b_raw;
        logic [BYTE_W-1:0] key_byte;
    } report_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  red_drive;
        logic [BYTE_W-1:0]  green_drive;
        logic [BYTE_W-1:0]  blue_drive;
        logic [BYTE_W-1:0]  slider_a_value;
        logic               slider_a_new;
        logic [BYTE_W-1:0]  slider_b_value;
        logic               slider_b_new;
        logic [BYTE_W-1:0]  keys_now;
        logic               key_new;
        logic               boot_request;
        logic [HOLDS_W-1:0] hold_counts;
    } result_t;

    function automatic logic [BYTE_W-1:0] remap_keys(input logic [BYTE_W-1:0] k);
        logic [BYTE_W-1:0] r;
        case (k)
            KEY_CODE_1: r = KEY_CODE_4;
            KEY_CODE_4: r = KEY_CODE_1;
            KEY_CODE_3: r = KEY_CODE_6;
            KEY_CODE_6: r = KEY_CODE_3;
            default:    r = k;
        endcase
        return r;
    endfunction

endpackage

[design/tprh_in_if.sv]
// Report channel: valid/ready handshake carrying one panel report.
interface tprh_in_if;
    import tprh_pkg::*;

    logic    valid;
    logic    ready;
    report_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

[design/tprh_out_if.sv]
// Result channel: valid/ready handshake carrying one result item.
interface tprh_out_if;
    import tprh_pkg::*;

    logic    valid;
    logic    ready;
    result_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

[design/touch_panel_report_handler.sv]
// Touch panel report handler: takes one report per cycle and returns one result item
// per report. A report is captured in an input register, processed by short logic that
// updates the slider, key, long-press, hold-counter and LED state, and the result lands
// in an output register; throughput is one item per cycle, limited only by the result
// side's ready. The user must write configuration (long press count, hold limit) via
// cfg_we/cfg_index/cfg_data only while no item is in flight; the block does not check.
module touch_panel_report_handler (
    input  logic                           clk,
    input  logic                           rst_n,
    tprh_in_if.sink                        report,
    tprh_out_if.source                     result,
    input  logic                           cfg_we,
    input  logic [tprh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tprh_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tprh_pkg::*;

    // configuration
    logic [BYTE_W-1:0] long_press_reg;
    logic [HOLD_W-1:0] hold_limit_reg;

    // input stage
    logic    in_valid_reg;
    report_t in_item_reg;

    // output stage
    logic    out_valid_reg;
    result_t out_item_reg;

    // block state
    logic [BYTE_W-1:0] prev_a_reg, prev_b_reg, value_a_reg, value_b_reg, prev_keys_reg;
    logic              red_on_reg, green_on_reg, blue_falling_reg;
    logic [BYTE_W-1:0] blue_level_reg, all_count_reg;
    logic [HOLD_W-1:0] hold_reg [NUM_KEYS];

    logic [BYTE_W-1:0] prev_a_next, prev_b_next, value_a_next, value_b_next, prev_keys_next;
    logic              red_on_next, green_on_next, blue_falling_next;
    logic [BYTE_W-1:0] blue_level_next, all_count_next;
    logic [HOLD_W-1:0] hold_next [NUM_KEYS];
    logic              a_new, b_new, k_new, boot;
    logic [BYTE_W-1:0] keys;
    result_t           res_next;

    logic advance;
    logic step;

    assign advance      = !out_valid_reg || result.ready;
    assign step         = advance && in_valid_reg;
    assign report.ready = !in_valid_reg || advance;
    assign result.valid = out_valid_reg;
    assign result.item  = out_item_reg;

    always_comb
    begin
        prev_a_next    = prev_a_reg;
        prev_b_next    = prev_b_reg;
        value_a_next   = value_a_reg;
        value_b_next   = value_b_reg;
        prev_keys_next = prev_keys_reg;
        red_on_next    = red_on_reg;
        green_on_next  = green_on_reg;
        a_new          = 1'b0;
        b_new          = 1'b0;
        k_new          = 1'b0;
        boot           = 1'b0;
        all_count_next = all_count_reg;

        if (in_item_reg.slider_a_raw != prev_a_reg)
        begin
            prev_a_next = in_item_reg.slider_a_raw;
            if (in_item_reg.slider_a_raw != SLIDER_IDLE)
            begin
                a_new         = 1'b1;
                value_a_next  = SLIDER_A_BASE - in_item_reg.slider_a_raw;
                green_on_next = 1'b1;
            end
            else
            begin
                green_on_next = 1'b0;
            end
        end
        // slider B decides green last
        if (in_item_reg.slider_b_raw != prev_b_reg)
        begin
            prev_b_next = in_item_reg.slider_b_raw;
            if (in_item_reg.slider_b_raw != SLIDER_IDLE)
            begin
                b_new         = 1'b1;
                value_b_next  = in_item_reg.slider_b_raw;
                green_on_next = 1'b1;
            end
            else
            begin
                green_on_next = 1'b0;
            end
        end

        keys = remap_keys(in_item_reg.key_byte);
        if (keys != prev_keys_reg)
        begin
            prev_keys_next = keys;
            if (keys[NUM_KEYS-1:0] != '0)
            begin
                k_new       = 1'b1;
                red_on_next = 1'b1;
            end
            else
            begin
                red_on_next = 1'b0;
            end
        end

        if (prev_keys_next[NUM_KEYS-1:0] == ALL_KEYS)
        begin
            if (all_count_reg < long_press_reg)
            begin
                all_count_next = all_count_reg + 8'd1;
            end
            else if (all_count_reg == long_press_reg && all_count_reg != COUNT_MAX)
            begin
                all_count_next = all_count_reg + 8'd1;
                boot           = 1'b1;
            end
        end
        else
        begin
            all_count_next = '0;
        end

        for (int i = 0; i < NUM_KEYS; i++)
        begin
            if (prev_keys_next[i])
            begin
                hold_next[i] = (hold_reg[i] < hold_limit_reg) ? hold_reg[i] + 7'd1
                                                              : hold_reg[i];
            end
            else
            begin
                hold_next[i] = '0;
            end
        end

        blue_level_next = blue_falling_reg ? blue_level_reg - BLUE_STEP
                                           : blue_level_reg + BLUE_STEP;
        if (blue_level_next == BLUE_TOP)
            blue_falling_next = 1'b1;
        else if (blue_level_next <= BLUE_STEP)
            blue_falling_next = 1'b0;
        else
            blue_falling_next = blue_falling_reg;

        res_next.red_drive      = red_on_next ? LED_FULL : LED_OFF;
        res_next.green_drive    = green_on_next ? LED_FULL : LED_OFF;
        res_next.blue_drive     = (red_on_next || green_on_next) ? LED_OFF : blue_level_next;
        res_next.slider_a_value = value_a_next;
        res_next.slider_a_new   = a_new;
        res_next.slider_b_value = value_b_next;
        res_next.slider_b_new   = b_new;
        res_next.keys_now       = prev_keys_next;
        res_next.key_new        = k_new;
        res_next.boot_request   = boot;
        res_next.hold_counts    = {hold_next[2], hold_next[1], hold_next[0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg   <= LONG_PRESS_RESET;
            hold_limit_reg   <= HOLD_LIMIT_RESET;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            prev_a_reg       <= '0;
            prev_b_reg       <= '0;
            value_a_reg      <= '0;
            value_b_reg      <= '0;
            prev_keys_reg    <= '0;
            red_on_reg       <= 1'b0;
            green_on_reg     <= 1'b0;
            blue_level_reg   <= '0;
            blue_falling_reg <= 1'b0;
            all_count_reg    <= '0;
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                hold_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_LONG_PRESS: long_press_reg <= cfg_data;
                    REG_HOLD_LIMIT: hold_limit_reg <= cfg_data[HOLD_W-1:0];
                    default: ;
                endcase
            end
            if (report.ready)
                in_valid_reg <= report.valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (step)
            begin
                prev_a_reg       <= prev_a_next;
                prev_b_reg       <= prev_b_next;
                value_a_reg      <= value_a_next;
                value_b_reg      <= value_b_next;
                prev_keys_reg    <= prev_keys_next;
                red_on_reg       <= red_on_next;
                green_on_reg     <= green_on_next;
                blue_level_reg   <= blue_level_next;
                blue_falling_reg <= blue_falling_next;
                all_count_reg    <= all_count_next;
                for (int i = 0; i < NUM_KEYS; i++)
                begin
                    hold_reg[i] <= hold_next[i];
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (report.ready)
            in_item_reg <= report.item;
        if (step)
            out_item_reg <= res_next;
    end

    // red LED always tracks whether any key bit of the stored key byte is set
    assert property (@(posedge clk) disable iff (!rst_n)
        red_on_reg == (prev_keys_reg[NUM_KEYS-1:0] != '0))
        else $error("red state out of step with stored keys");

    // a nonzero hold counter needs its key held
    assert property (@(posedge clk) disable iff (!rst_n)
        ((hold_reg[0] == '0) || prev_keys_reg[0]) && ((hold_reg[1] == '0) || prev_keys_reg[1])
        && ((hold_reg[2] == '0) || prev_keys_reg[2]))
        else $error("hold counter running for a released key");

    // falling blue never sits at the bottom of its range
    assert property (@(posedge clk) disable iff (!rst_n)
        blue_falling_reg |-> (blue_level_reg > BLUE_STEP))
        else $error("blue falling at bottom level");

    // bootloader pulse only with all keys held
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.boot_request)
        |-> (out_item_reg.keys_now[NUM_KEYS-1:0] == ALL_KEYS))
        else $error("boot request without all keys held");

    // a finished result moves out only when the next stage takes it
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !result.ready) |=> (in_valid_reg && out_valid_reg))
        else $error("item dropped while result stalled");

endmodule
